>>> rtl/packet_weighted_mean_anomaly_marker_unit_macros.svh
// Assertion macros shared by the anomaly marker RTL.
`ifndef PACKET_WEIGHTED_MEAN_ANOMALY_MARKER_UNIT_MACROS_SVH
`define PACKET_WEIGHTED_MEAN_ANOMALY_MARKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define PWMAM_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define PWMAM_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> rtl/pwmam_pkg.sv
// Shared constants, register codes and types of the anomaly marker.
`timescale 1ns / 1ps
package pwmam_pkg;

    localparam int unsigned WEIGHT_SHIFT_DEF = 16;
    localparam int unsigned SCORE_SHIFT_DEF  = 11;
    localparam int unsigned QUEUE_DEPTH_DEF  = 4;

    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned WEIGHT_W    = 17;
    localparam int unsigned WINDOW_W    = 16;
    localparam int unsigned MODE_W      = 2;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned PRODUCT_W   = VALUE_W + WEIGHT_W;

    localparam logic [MODE_W-1:0] MODE_ADAPTIVE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STATIC   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MARK_ALL = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_MODE               = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STATIC_THRESHOLD   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SIZE        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_FIRST       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_SECOND      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_WINDOW_MEAN = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_HISTORY     = 3'd6;

    localparam logic [MODE_W-1:0]   RST_MODE               = MODE_ADAPTIVE;
    localparam logic [VALUE_W-1:0]  RST_STATIC_THRESHOLD   = 32'd142;
    localparam logic [WINDOW_W-1:0] RST_WINDOW_SIZE        = 16'd1024;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_FIRST       = 17'd45875;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_SECOND      = 17'd19660;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_WINDOW_MEAN = 17'd19660;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_HISTORY     = 17'd45875;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [VALUE_W-1:0]  static_threshold;
        logic [WINDOW_W-1:0] window_size;
        logic [WEIGHT_W-1:0] weight_first;
        logic [WEIGHT_W-1:0] weight_second;
        logic [WEIGHT_W-1:0] weight_window_mean;
        logic [WEIGHT_W-1:0] weight_history;
    } cfg_t;

    typedef struct packed {
        logic               mark;
        logic [VALUE_W-1:0] packet_total;
        logic [VALUE_W-1:0] second_report;
        logic [VALUE_W-1:0] history_report;
    } result_t;

endpackage

>>> rtl/pwmam_if.sv
// Channel interfaces of the anomaly marker: packet words, result words, register writes.
`timescale 1ns / 1ps
interface pwmam_pkt_if;
    logic                           valid;
    logic                           ready;
    logic [pwmam_pkg::VALUE_W-1:0]  first_value;
    logic [pwmam_pkg::VALUE_W-1:0]  second_value;

    modport source (output valid, output first_value, output second_value, input ready);
    modport sink   (input valid, input first_value, input second_value, output ready);
endinterface

interface pwmam_res_if;
    logic                           valid;
    logic                           ready;
    logic                           mark;
    logic [pwmam_pkg::VALUE_W-1:0]  packet_total;
    logic [pwmam_pkg::VALUE_W-1:0]  second_report;
    logic [pwmam_pkg::VALUE_W-1:0]  history_report;

    modport source (output valid, output mark, output packet_total, output second_report,
                    output history_report, input ready);
    modport sink   (input valid, input mark, input packet_total, input second_report,
                    input history_report, output ready);
endinterface

interface pwmam_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pwmam_pkg::CFG_INDEX_W-1:0] index;
    logic [pwmam_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/pwmam_front.sv
// Front end: accepts packet words, forms the weighted score and pushes it into the queue.
`timescale 1ns / 1ps
module pwmam_front #(
    parameter int unsigned WEIGHT_SHIFT = pwmam_pkg::WEIGHT_SHIFT_DEF,
    parameter int unsigned SCORE_SHIFT  = pwmam_pkg::SCORE_SHIFT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    pwmam_pkt_if.sink                     pkt,
    input  pwmam_pkg::cfg_t               cfg,
    input  logic                          queue_full,
    output logic                          push,
    output logic [pwmam_pkg::VALUE_W-1:0] push_score
);

    localparam int unsigned PW = pwmam_pkg::PRODUCT_W;
    localparam int unsigned VW = pwmam_pkg::VALUE_W;

    logic          s1_valid_reg, s1_valid_next;
    logic [PW-1:0] prod_first_reg, prod_first_next;
    logic [VW-1:0] prod_second_reg, prod_second_next;
    logic [PW-1:0] prod_second_full;
    logic [PW-1:0] term_first, term_second, score_sum, score_full;
    logic          accept;

    assign pkt.ready = !s1_valid_reg || !queue_full;
    assign accept    = pkt.valid && pkt.ready;
    assign push      = s1_valid_reg && !queue_full;

    // The second product keeps only its low word before scaling.
    assign prod_first_next  = PW'(cfg.weight_first) * PW'(pkt.first_value);
    assign prod_second_full = PW'(cfg.weight_second) * PW'(pkt.second_value);
    assign prod_second_next = prod_second_full[VW-1:0];

    assign term_first  = prod_first_reg >> WEIGHT_SHIFT;
    assign term_second = PW'(prod_second_reg >> WEIGHT_SHIFT);
    assign score_sum   = term_first + term_second;
    assign score_full  = score_sum >> SCORE_SHIFT;
    assign push_score  = score_full[VW-1:0];

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (push)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_first_reg  <= prod_first_next;
            prod_second_reg <= prod_second_next;
        end
    end

endmodule

>>> rtl/pwmam_queue.sv
// Short score queue between the front end and the back end.
`timescale 1ns / 1ps
`include "packet_weighted_mean_anomaly_marker_unit_macros.svh"
module pwmam_queue #(
    parameter int unsigned WIDTH = pwmam_pkg::VALUE_W,
    parameter int unsigned DEPTH = pwmam_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   mem_reg [DEPTH];
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == COUNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[head_reg];

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (pop)
        begin
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[tail_reg] <= push_data;
        end
    end

    `PWMAM_ASSERT_IMP(a_no_push_when_full, clk, rst_n, push, !full, "push into a full queue")
    `PWMAM_ASSERT_IMP(a_no_pop_when_empty, clk, rst_n, pop, not_empty, "pop from an empty queue")
    `PWMAM_ASSERT_NEXT(a_count_grows, clk, rst_n, push && !pop, count_reg == COUNT_W'($past(count_reg) + 1'b1), "queue count did not follow a push")

endmodule

>>> rtl/pwmam_back.sv
// Back end: counters, window accumulation, serial window divide, history blend, result register.
`timescale 1ns / 1ps
`include "packet_weighted_mean_anomaly_marker_unit_macros.svh"
module pwmam_back #(
    parameter int unsigned WEIGHT_SHIFT = pwmam_pkg::WEIGHT_SHIFT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pwmam_pkg::cfg_t               cfg,
    input  logic                          q_valid,
    input  logic [pwmam_pkg::VALUE_W-1:0] q_score,
    output logic                          pop,
    pwmam_res_if.source                   res
);

    localparam int unsigned VW      = pwmam_pkg::VALUE_W;
    localparam int unsigned WW      = pwmam_pkg::WINDOW_W;
    localparam int unsigned PW      = pwmam_pkg::PRODUCT_W;
    localparam int unsigned DVW     = WW + 1;
    localparam int unsigned DIV_CW  = $clog2(VW);
    localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(VW - 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_BLEND = 4'b0100,
        ST_SUM   = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [VW-1:0]       packet_counter_reg, packet_counter_next;
    logic [VW-1:0]       marked_counter_reg, marked_counter_next;
    logic [WW-1:0]       window_counter_reg, window_counter_next;
    logic [VW-1:0]       score_acc_reg, score_acc_next;
    logic [VW-1:0]       history_mean_reg, history_mean_next;
    logic                res_valid_reg, res_valid_next;
    logic [DIV_CW-1:0]   div_count_reg, div_count_next;

    pwmam_pkg::result_t  res_data_reg, res_data_next;
    logic [VW-1:0]       quot_reg, quot_next;
    logic [DVW-1:0]      rem_reg, rem_next;
    logic [DVW-1:0]      divisor_reg, divisor_next;
    logic [PW-1:0]       prod_mean_reg, prod_mean_next;
    logic [PW-1:0]       prod_hist_reg, prod_hist_next;

    logic                slot_free;
    logic [VW-1:0]       packet_inc, marked_inc, acc_sum;
    logic [WW-1:0]       window_inc;
    logic                hist_nonzero, window_close;
    logic [DVW:0]        trial;
    logic                trial_ge;
    logic [DVW-1:0]      rem_step;
    logic [VW-1:0]       quot_step;
    logic [PW-1:0]       blend_sum;

    assign slot_free    = !res_valid_reg || res.ready;
    assign pop          = (state_reg == ST_IDLE) && q_valid && slot_free;
    assign packet_inc   = packet_counter_reg + 1'b1;
    assign marked_inc   = marked_counter_reg + 1'b1;
    assign acc_sum      = score_acc_reg + q_score;
    assign window_inc   = window_counter_reg + 1'b1;
    assign hist_nonzero = (history_mean_reg != '0);
    assign window_close = (window_inc == cfg.window_size);

    // One restoring step of the window divide per cycle, quotient bits shift in at the bottom.
    assign trial     = {rem_reg, quot_reg[VW-1]};
    assign trial_ge  = (trial >= {1'b0, divisor_reg});
    assign rem_step  = trial_ge ? DVW'(trial - {1'b0, divisor_reg}) : trial[DVW-1:0];
    assign quot_step = {quot_reg[VW-2:0], trial_ge};

    assign blend_sum = (prod_mean_reg >> WEIGHT_SHIFT) + (prod_hist_reg >> WEIGHT_SHIFT);

    always_comb
    begin
        state_next          = state_reg;
        packet_counter_next = packet_counter_reg;
        marked_counter_next = marked_counter_reg;
        window_counter_next = window_counter_reg;
        score_acc_next      = score_acc_reg;
        history_mean_next   = history_mean_reg;
        div_count_next      = div_count_reg;
        res_valid_next      = res_valid_reg && !res.ready;
        res_data_next       = res_data_reg;
        quot_next           = quot_reg;
        rem_next            = rem_reg;
        divisor_next        = divisor_reg;
        prod_mean_next      = prod_mean_reg;
        prod_hist_next      = prod_hist_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    packet_counter_next         = packet_inc;
                    res_data_next.packet_total  = packet_inc;
                    res_data_next.history_report = history_mean_reg;
                    res_valid_next              = 1'b1;
                    priority if (cfg.mode == pwmam_pkg::MODE_MARK_ALL)
                    begin
                        res_data_next.mark          = 1'b1;
                        res_data_next.second_report = packet_inc;
                    end
                    else if (cfg.mode == pwmam_pkg::MODE_STATIC)
                    begin
                        res_data_next.mark          = (q_score > cfg.static_threshold);
                        res_data_next.second_report = marked_counter_reg;
                        if (q_score > cfg.static_threshold)
                        begin
                            marked_counter_next         = marked_inc;
                            res_data_next.second_report = marked_inc;
                        end
                    end
                    else
                    begin
                        // Adaptive mode; the spare mode code behaves the same way.
                        res_data_next.mark          = (q_score > history_mean_reg) && hist_nonzero;
                        res_data_next.second_report = marked_counter_reg;
                        if ((q_score > history_mean_reg) && hist_nonzero)
                        begin
                            marked_counter_next         = marked_inc;
                            res_data_next.second_report = marked_inc;
                        end
                        if (window_close)
                        begin
                            window_counter_next = '0;
                            score_acc_next      = '0;
                            quot_next           = acc_sum;
                            rem_next            = '0;
                            divisor_next        = (cfg.window_size == '0) ?
                                                  {1'b1, {WW{1'b0}}} : {1'b0, cfg.window_size};
                            div_count_next      = '0;
                            res_valid_next      = 1'b0;
                            state_next          = ST_DIV;
                        end
                        else
                        begin
                            window_counter_next = window_inc;
                            score_acc_next      = acc_sum;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                rem_next       = rem_step;
                quot_next      = quot_step;
                div_count_next = div_count_reg + 1'b1;
                if (div_count_reg == DIV_LAST)
                begin
                    if (hist_nonzero)
                    begin
                        state_next = ST_BLEND;
                    end
                    else
                    begin
                        history_mean_next            = quot_step;
                        res_data_next.history_report = quot_step;
                        res_valid_next               = 1'b1;
                        state_next                   = ST_IDLE;
                    end
                end
            end
            ST_BLEND:
            begin
                prod_mean_next = PW'(quot_reg) * PW'(cfg.weight_window_mean);
                prod_hist_next = PW'(cfg.weight_history) * PW'(history_mean_reg);
                state_next     = ST_SUM;
            end
            ST_SUM:
            begin
                history_mean_next            = blend_sum[VW-1:0];
                res_data_next.history_report = blend_sum[VW-1:0];
                res_valid_next               = 1'b1;
                state_next                   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            packet_counter_reg <= '0;
            marked_counter_reg <= '0;
            window_counter_reg <= '0;
            score_acc_reg      <= '0;
            history_mean_reg   <= '0;
            res_valid_reg      <= 1'b0;
            div_count_reg      <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            packet_counter_reg <= packet_counter_next;
            marked_counter_reg <= marked_counter_next;
            window_counter_reg <= window_counter_next;
            score_acc_reg      <= score_acc_next;
            history_mean_reg   <= history_mean_next;
            res_valid_reg      <= res_valid_next;
            div_count_reg      <= div_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg  <= res_data_next;
        quot_reg      <= quot_next;
        rem_reg       <= rem_next;
        divisor_reg   <= divisor_next;
        prod_mean_reg <= prod_mean_next;
        prod_hist_reg <= prod_hist_next;
    end

    assign res.valid          = res_valid_reg;
    assign res.mark           = res_data_reg.mark;
    assign res.packet_total   = res_data_reg.packet_total;
    assign res.second_report  = res_data_reg.second_report;
    assign res.history_report = res_data_reg.history_report;

    `PWMAM_ASSERT_IMP(a_div_slot_empty, clk, rst_n, state_reg != ST_IDLE, !res_valid_reg, "result register busy during window close")
    `PWMAM_ASSERT_NEXT(a_div_ends, clk, rst_n, (state_reg == ST_DIV) && (div_count_reg == DIV_LAST), state_reg != ST_DIV, "window divide ran past its last step")
    `PWMAM_ASSERT_NEXT(a_sum_delivers, clk, rst_n, state_reg == ST_SUM, res_valid_reg && (res_data_reg.history_report == history_mean_reg), "blended history not reported")

endmodule

>>> rtl/packet_weighted_mean_anomaly_marker_unit.sv
// Top level of the packet weighted-mean anomaly marker with its register file.
`timescale 1ns / 1ps
// Each packet word (two 32-bit header metrics) yields exactly one result word carrying the
// mark bit, the running packet count, the marked count (the packet count in mark-all mode)
// and the history mean after that packet. The front end takes one word per cycle while the
// queue is not full: it registers the two weight products and pushes the score into a
// queue of QUEUE_DEPTH words, and with an idle output the back end moves it on into the
// result register. The back end retires one word per cycle as long as the result
// register is free. A packet that closes an adaptive window keeps the back end busy
// longer, because the window mean comes from a bit-serial divider, followed by the two
// blend products and their sum when the history is already nonzero. During that time the
// front end keeps filling the queue and stalls only once it is full. Registers are written
// over the configuration channel, which is always ready; writes are meant to happen only
// while no packet is in flight. Indexes beyond the register list are ignored.
module packet_weighted_mean_anomaly_marker_unit #(
    parameter int unsigned WEIGHT_SHIFT = pwmam_pkg::WEIGHT_SHIFT_DEF,
    parameter int unsigned SCORE_SHIFT  = pwmam_pkg::SCORE_SHIFT_DEF,
    parameter int unsigned QUEUE_DEPTH  = pwmam_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    pwmam_pkt_if.sink   pkt,
    pwmam_res_if.source res,
    pwmam_cfg_if.sink   cfg
);

    pwmam_pkg::cfg_t               cfg_reg, cfg_next;
    logic                          push, queue_full, pop, q_valid;
    logic [pwmam_pkg::VALUE_W-1:0] push_score, q_score;

    // The register file accepts a write in every cycle.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                pwmam_pkg::REG_MODE:
                begin
                    cfg_next.mode = cfg.data[pwmam_pkg::MODE_W-1:0];
                end
                pwmam_pkg::REG_STATIC_THRESHOLD:
                begin
                    cfg_next.static_threshold = cfg.data[pwmam_pkg::VALUE_W-1:0];
                end
                pwmam_pkg::REG_WINDOW_SIZE:
                begin
                    cfg_next.window_size = cfg.data[pwmam_pkg::WINDOW_W-1:0];
                end
                pwmam_pkg::REG_WEIGHT_FIRST:
                begin
                    cfg_next.weight_first = cfg.data[pwmam_pkg::WEIGHT_W-1:0];
                end
                pwmam_pkg::REG_WEIGHT_SECOND:
                begin
                    cfg_next.weight_second = cfg.data[pwmam_pkg::WEIGHT_W-1:0];
                end
                pwmam_pkg::REG_WEIGHT_WINDOW_MEAN:
                begin
                    cfg_next.weight_window_mean = cfg.data[pwmam_pkg::WEIGHT_W-1:0];
                end
                pwmam_pkg::REG_WEIGHT_HISTORY:
                begin
                    cfg_next.weight_history = cfg.data[pwmam_pkg::WEIGHT_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode               <= pwmam_pkg::RST_MODE;
            cfg_reg.static_threshold   <= pwmam_pkg::RST_STATIC_THRESHOLD;
            cfg_reg.window_size        <= pwmam_pkg::RST_WINDOW_SIZE;
            cfg_reg.weight_first       <= pwmam_pkg::RST_WEIGHT_FIRST;
            cfg_reg.weight_second      <= pwmam_pkg::RST_WEIGHT_SECOND;
            cfg_reg.weight_window_mean <= pwmam_pkg::RST_WEIGHT_WINDOW_MEAN;
            cfg_reg.weight_history     <= pwmam_pkg::RST_WEIGHT_HISTORY;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: product stage, then the score goes into the queue.
    pwmam_front #(
        .WEIGHT_SHIFT (WEIGHT_SHIFT),
        .SCORE_SHIFT  (SCORE_SHIFT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pkt        (pkt),
        .cfg        (cfg_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_score (push_score)
    );

    // The queue lets the front end keep taking packets while a window closes.
    pwmam_queue #(
        .WIDTH (pwmam_pkg::VALUE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_score),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (q_valid),
        .pop_data  (q_score)
    );

    // Back end: all packet state lives here, next to the result register.
    pwmam_back #(
        .WEIGHT_SHIFT (WEIGHT_SHIFT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_score (q_score),
        .pop     (pop),
        .res     (res)
    );

endmodule

>>> tb/packet_weighted_mean_anomaly_marker_unit_tb.sv
// Self-checking testbench of the packet weighted-mean anomaly marker.
`timescale 1ns / 1ps
module packet_weighted_mean_anomaly_marker_unit_tb;
    import pwmam_pkg::*;

    // Codes that the package leaves unnamed: the fourth mode value and the one
    // register index past the end of the register list.
    localparam logic [MODE_W-1:0]      MODE_UNUSED = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED  = 3'd7;

    // Settle time at the end, covering a closing window in the back end and the pipe ahead of it.
    localparam int unsigned END_SETTLE         = 40;
    // Cycles in a row with no word moving on any channel before the run is called hung.
    localparam int unsigned STALL_LIMIT        = 5000;
    localparam int unsigned SETTINGS_PER_PHASE = 6;
    localparam int unsigned WORDS_PER_SETTING  = 22;
    // A short burst with a zero window size, far below the wrap of the window counter.
    localparam int unsigned ZERO_WINDOW_WORDS  = 8;

    typedef enum logic {ROW_PACKET, ROW_REG} row_kind_t;

    // One row of the directed table. A packet row carries the two header metrics; a
    // register row carries its write data in first_value. Rows with typed set hold the
    // result word that is expected in want; all others are checked against the predictor.
    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] index;
        logic [VALUE_W-1:0]     first_value;
        logic [VALUE_W-1:0]     second_value;
        logic                   typed;
        result_t                want;
    } stim_row_t;

    localparam int unsigned DIRECTED_COUNT = 36;
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // Right after reset: adaptive mode, history still zero, so nothing is marked.
        '{ROW_PACKET, '0, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 32'd1, 32'd0, 32'd0}},
        '{ROW_PACKET, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'd2, 32'd0, 32'd0}},
        '{ROW_PACKET, '0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b0, 32'd3, 32'd0, 32'd0}},
        '{ROW_PACKET, '0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'd4, 32'd0, 32'd0}},
        // Static mode with a zero threshold: a zero score is not above it, a full one is.
        '{ROW_REG, REG_MODE, {30'h0, MODE_STATIC}, 32'h0, 1'b0, '0},
        '{ROW_REG, REG_STATIC_THRESHOLD, 32'h0000_0000, 32'h0, 1'b0, '0},
        '{ROW_PACKET, '0, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 32'd5, 32'd0, 32'd0}},
        '{ROW_PACKET, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'd6, 32'd1, 32'd0}},
        // The largest threshold can never be exceeded.
        '{ROW_REG, REG_STATIC_THRESHOLD, 32'hFFFF_FFFF, 32'h0, 1'b0, '0},
        '{ROW_PACKET, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'd7, 32'd1, 32'd0}},
        // Mark-all mode reports the packet count in place of the marked count.
        '{ROW_REG, REG_MODE, {30'h0, MODE_MARK_ALL}, 32'h0, 1'b0, '0},
        '{ROW_PACKET, '0, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'd8, 32'd8, 32'd0}},
        '{ROW_PACKET, '0, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, '0},
        // The unused mode code acts as adaptive mode. Four packets are already in the
        // window, so a window of five closes on the next packet. Weights above one and
        // a write to the index past the register list come along here too.
        '{ROW_REG, REG_MODE, {30'h3FFF_FFFF, MODE_UNUSED}, 32'h0, 1'b0, '0},
        '{ROW_REG, REG_WINDOW_SIZE, 32'hFFFF_0005, 32'h0, 1'b0, '0},
        '{ROW_REG, REG_WEIGHT_FIRST, 32'hFFFF_FFFF, 32'h0, 1'b0, '0},
        '{ROW_REG, REG_WEIGHT_SECOND, 32'h0001_0000, 32'h0, 1'b0, '0},
        '{ROW_REG, REG_WEIGHT_WINDOW_MEAN, 32'h0001_0000, 32'h0, 1'b0, '0},
        '{ROW_REG, REG_WEIGHT_HISTORY, 32'hFFFF_FFFF, 32'h0, 1'b0, '0},
        '{ROW_REG, REG_UNUSED, 32'hDEAD_BEEF, 32'h0, 1'b0, '0},
        '{ROW_PACKET, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_PACKET, '0, 32'h0000_FFFF, 32'hFFFF_0000, 1'b0, '0},
        '{ROW_PACKET, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
        // Zero score weights and a window of three: the next close blends the history.
        '{ROW_REG, REG_MODE, {30'h0, MODE_ADAPTIVE}, 32'h0, 1'b0, '0},
        '{ROW_REG, REG_WINDOW_SIZE, 32'h0000_0003, 32'h0, 1'b0, '0},
        '{ROW_REG, REG_WEIGHT_FIRST, 32'h0000_0000, 32'h0, 1'b0, '0},
        '{ROW_REG, REG_WEIGHT_SECOND, 32'h0000_0000, 32'h0, 1'b0, '0},
        '{ROW_PACKET, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_PACKET, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_PACKET, '0, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        // Back to the reset weights with the largest nonzero window size.
        '{ROW_REG, REG_WEIGHT_FIRST, {15'h0, RST_WEIGHT_FIRST}, 32'h0, 1'b0, '0},
        '{ROW_REG, REG_WEIGHT_SECOND, {15'h0, RST_WEIGHT_SECOND}, 32'h0, 1'b0, '0},
        '{ROW_REG, REG_WEIGHT_WINDOW_MEAN, {15'h0, RST_WEIGHT_WINDOW_MEAN}, 32'h0, 1'b0, '0},
        '{ROW_REG, REG_WEIGHT_HISTORY, {15'h0, RST_WEIGHT_HISTORY}, 32'h0, 1'b0, '0},
        '{ROW_REG, REG_WINDOW_SIZE, 32'h0000_FFFF, 32'h0, 1'b0, '0},
        '{ROW_PACKET, '0, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, '0}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    pwmam_pkt_if pkt_ch ();
    pwmam_res_if res_ch ();
    pwmam_cfg_if cfg_ch ();

    packet_weighted_mean_anomaly_marker_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // Half a period of 1 ns gives the 2 ns clock.
    always #1 clk = ~clk;

    // Shadow copy of the block's registers and state, kept by the predictor.
    cfg_t               model_cfg;
    logic [VALUE_W-1:0] model_packets;
    logic [VALUE_W-1:0] model_marked;
    logic [WINDOW_W-1:0] model_window_count;
    logic [VALUE_W-1:0] model_score_sum;
    logic [VALUE_W-1:0] model_history;

    // Result words predicted for accepted packets, oldest first.
    result_t pending_results [$];

    int unsigned mismatches   = 0;
    int unsigned stall_cycles = 0;
    int unsigned pkt_idle_pct = 34;
    int unsigned res_idle_pct = 87;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic void reset_marker_model();
        model_cfg.mode               = RST_MODE;
        model_cfg.static_threshold   = RST_STATIC_THRESHOLD;
        model_cfg.window_size        = RST_WINDOW_SIZE;
        model_cfg.weight_first       = RST_WEIGHT_FIRST;
        model_cfg.weight_second      = RST_WEIGHT_SECOND;
        model_cfg.weight_window_mean = RST_WEIGHT_WINDOW_MEAN;
        model_cfg.weight_history     = RST_WEIGHT_HISTORY;
        model_packets      = '0;
        model_marked       = '0;
        model_window_count = '0;
        model_score_sum    = '0;
        model_history      = '0;
    endfunction

    // Each register keeps only its own width of the write data; unknown indexes are dropped.
    function automatic void apply_reg_write(input logic [CFG_INDEX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_MODE:               model_cfg.mode               = data[MODE_W-1:0];
            REG_STATIC_THRESHOLD:   model_cfg.static_threshold   = data[VALUE_W-1:0];
            REG_WINDOW_SIZE:        model_cfg.window_size        = data[WINDOW_W-1:0];
            REG_WEIGHT_FIRST:       model_cfg.weight_first       = data[WEIGHT_W-1:0];
            REG_WEIGHT_SECOND:      model_cfg.weight_second      = data[WEIGHT_W-1:0];
            REG_WEIGHT_WINDOW_MEAN: model_cfg.weight_window_mean = data[WEIGHT_W-1:0];
            REG_WEIGHT_HISTORY:     model_cfg.weight_history     = data[WEIGHT_W-1:0];
            default: ;
        endcase
    endfunction

    // Scores one packet, updates the shadow state and returns the result word it causes.
    function automatic result_t advance_marker(input logic [VALUE_W-1:0] a,
                                               input logic [VALUE_W-1:0] b);
        logic [63:0]        term_first;
        logic [63:0]        term_second;
        logic [VALUE_W-1:0] product_second;
        logic [VALUE_W-1:0] score;
        logic [VALUE_W-1:0] prior_history;
        logic [63:0]        divisor;
        logic [63:0]        window_mean;
        logic [63:0]        blend_mean;
        logic [63:0]        blend_history;
        result_t            word;

        // The first product is kept whole; the second one loses everything above 32 bits
        // before it is scaled.
        term_first     = (64'(model_cfg.weight_first) * 64'(a)) >> WEIGHT_SHIFT_DEF;
        product_second = 32'(64'(model_cfg.weight_second) * 64'(b));
        term_second    = 64'(product_second >> WEIGHT_SHIFT_DEF);
        score          = 32'((term_first + term_second) >> SCORE_SHIFT_DEF);

        model_packets = model_packets + 32'd1;
        word.mark     = 1'b0;

        if (model_cfg.mode == MODE_MARK_ALL)
        begin
            word.mark          = 1'b1;
            word.second_report = model_packets;
        end
        else if (model_cfg.mode == MODE_STATIC)
        begin
            if (score > model_cfg.static_threshold)
            begin
                word.mark    = 1'b1;
                model_marked = model_marked + 32'd1;
            end
            word.second_report = model_marked;
        end
        else
        begin
            // Adaptive mode, which the unused mode code falls into as well.
            prior_history      = model_history;
            model_window_count = model_window_count + 16'd1;
            model_score_sum    = model_score_sum + score;
            if (score > prior_history && prior_history != '0)
            begin
                word.mark    = 1'b1;
                model_marked = model_marked + 32'd1;
            end
            if (model_window_count == model_cfg.window_size)
            begin
                // A zero window size can only match after the counter wraps, so the
                // window then spans 65536 packets.
                divisor = (model_cfg.window_size == '0) ? 64'd65536
                                                        : 64'(model_cfg.window_size);
                window_mean        = 64'(model_score_sum) / divisor;
                model_window_count = '0;
                model_score_sum    = '0;
                if (prior_history != '0)
                begin
                    blend_mean = (window_mean * 64'(model_cfg.weight_window_mean))
                                 >> WEIGHT_SHIFT_DEF;
                    blend_history = (64'(model_cfg.weight_history) * 64'(prior_history))
                                    >> WEIGHT_SHIFT_DEF;
                    model_history = 32'(blend_mean + blend_history);
                end
                else
                begin
                    model_history = 32'(window_mean);
                end
            end
            word.second_report = model_marked;
        end

        word.packet_total   = model_packets;
        word.history_report = model_history;
        return word;
    endfunction

    // Offers one packet word, with random idle cycles ahead of it, and records what it
    // should produce once the block takes it. Valid stays high on return so that a
    // following packet can go out back to back.
    task automatic push_packet(input logic [VALUE_W-1:0] a, input logic [VALUE_W-1:0] b,
                               input logic typed, input result_t want);
        result_t predicted;
        while ($urandom_range(99) < pkt_idle_pct)
        begin
            pkt_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pkt_ch.first_value  <= a;
        pkt_ch.second_value <= b;
        pkt_ch.valid        <= 1'b1;
        do @(posedge clk); while (!pkt_ch.ready);
        predicted = advance_marker(a, b);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Writes one register. Valid is left high; the caller drops it after the last write
    // of a group so back-to-back writes never toggle it within one step.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        cfg_ch.valid <= 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        apply_reg_write(idx, data);
    endtask

    // Stops offering packets and waits for every predicted result word to come back.
    // Each packet yields a result, so the block is idle once the queue is empty.
    task automatic drain_results();
        pkt_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // Sets the bits above a register's width at random, since the block must drop them.
    function automatic logic [CFG_DATA_W-1:0] with_noise(input logic [CFG_DATA_W-1:0] value,
                                                         input int unsigned width);
        logic [CFG_DATA_W-1:0] keep;
        keep = (32'h1 << width) - 32'h1;
        return ($urandom() & ~keep) | (value & keep);
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(4))
            0:       return '0;
            1:       return 17'd65536;
            2:       return '1;
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] random_metric();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return 32'($urandom_range(65535));
            default: return $urandom();
        endcase
    endfunction

    // Programs a fresh random setting into all seven registers. Adaptive mode gets most of
    // the weight because it holds the deepest behavior.
    task automatic program_setting();
        logic [MODE_W-1:0]   mode_code;
        logic [VALUE_W-1:0]  threshold;
        logic [WINDOW_W-1:0] window;
        int unsigned         pick;

        pick = $urandom_range(9);
        if (pick < 6)
        begin
            mode_code = MODE_ADAPTIVE;
        end
        else if (pick == 6)
        begin
            mode_code = MODE_UNUSED;
        end
        else if (pick == 7)
        begin
            mode_code = MODE_MARK_ALL;
        end
        else
        begin
            mode_code = MODE_STATIC;
        end

        // Scores reach about 2^22 at most, so most thresholds sit in that range.
        case ($urandom_range(4))
            0:       threshold = '0;
            1:       threshold = '1;
            2:       threshold = $urandom();
            default: threshold = 32'($urandom_range(1 << 22));
        endcase

        case ($urandom_range(9))
            0:       window = '1;
            1:       window = 16'($urandom_range(65535, 1));
            default: window = 16'($urandom_range(6, 1));
        endcase
        // A window no longer than the packets already counted would only close after the
        // counter wraps, so it is stretched just past the current count.
        if (window <= model_window_count)
        begin
            window = model_window_count + 16'($urandom_range(3, 1));
        end

        write_reg(REG_MODE, with_noise(32'(mode_code), MODE_W));
        write_reg(REG_STATIC_THRESHOLD, threshold);
        write_reg(REG_WINDOW_SIZE, with_noise(32'(window), WINDOW_W));
        write_reg(REG_WEIGHT_FIRST, with_noise(32'(pick_weight()), WEIGHT_W));
        write_reg(REG_WEIGHT_SECOND, with_noise(32'(pick_weight()), WEIGHT_W));
        write_reg(REG_WEIGHT_WINDOW_MEAN, with_noise(32'(pick_weight()), WEIGHT_W));
        write_reg(REG_WEIGHT_HISTORY, with_noise(32'(pick_weight()), WEIGHT_W));
        cfg_ch.valid <= 1'b0;
    endtask

    // Result side: takes words with random back pressure and compares each field with the
    // oldest prediction.
    initial
    begin : result_sink
        result_t want;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("result word with nothing pending, packet_total",
                                    res_ch.packet_total, '0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (res_ch.mark !== want.mark)
                    begin
                        report_mismatch("mark", 32'(res_ch.mark), 32'(want.mark));
                    end
                    if (res_ch.packet_total !== want.packet_total)
                    begin
                        report_mismatch("packet_total", res_ch.packet_total,
                                        want.packet_total);
                    end
                    if (res_ch.second_report !== want.second_report)
                    begin
                        report_mismatch("second_report", res_ch.second_report,
                                        want.second_report);
                    end
                    if (res_ch.history_report !== want.history_report)
                    begin
                        report_mismatch("history_report", res_ch.history_report,
                                        want.history_report);
                    end
                end
            end
            res_ch.ready <= ($urandom_range(99) >= res_idle_pct);
        end
    end

    // Hang detection: the run is over once no word has moved on any channel for too long.
    initial
    begin : watchdog
        @(posedge rst_n);
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((pkt_ch.valid && pkt_ch.ready) || (res_ch.valid && res_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t row;

        pkt_ch.valid        <= 1'b0;
        pkt_ch.first_value  <= '0;
        pkt_ch.second_value <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= '0;
        cfg_ch.data         <= '0;
        reset_marker_model();

        // Reset is held from the start and released on a clock edge.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table. Register rows come in groups; each group waits for the block
        // to go idle first and drops the write valid once it is done.
        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            row = DIRECTED_ROWS[i];
            if (row.kind == ROW_REG)
            begin
                if (i == 0 || DIRECTED_ROWS[i-1].kind != ROW_REG)
                begin
                    drain_results();
                end
                write_reg(row.index, row.first_value);
                if (i == DIRECTED_COUNT - 1 || DIRECTED_ROWS[i+1].kind != ROW_REG)
                begin
                    cfg_ch.valid <= 1'b0;
                end
            end
            else
            begin
                push_packet(row.first_value, row.second_value, row.typed, row.want);
            end
        end

        // Random part in three idling phases: a slow receiver, then a slow sender, then
        // both running flat out. Each phase walks through several register settings.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    pkt_idle_pct = 34;
                    res_idle_pct = 87;
                end
                1:
                begin
                    pkt_idle_pct = 87;
                    res_idle_pct = 34;
                end
                default:
                begin
                    pkt_idle_pct = 0;
                    res_idle_pct = 0;
                end
            endcase
            for (int s = 0; s < SETTINGS_PER_PHASE; s++)
            begin
                drain_results();
                program_setting();
                repeat (WORDS_PER_SETTING) push_packet(random_metric(), random_metric(),
                                                       1'b0, '0);
            end
        end

        // A zero window size closes the window only when the 16-bit counter wraps, so a
        // short burst of adaptive packets must not close it.
        drain_results();
        write_reg(REG_MODE, with_noise(32'(MODE_ADAPTIVE), MODE_W));
        write_reg(REG_WINDOW_SIZE, with_noise(32'h0, WINDOW_W));
        write_reg(REG_WEIGHT_FIRST, with_noise(32'(RST_WEIGHT_FIRST), WEIGHT_W));
        write_reg(REG_WEIGHT_SECOND, with_noise(32'(RST_WEIGHT_SECOND), WEIGHT_W));
        cfg_ch.valid <= 1'b0;
        repeat (ZERO_WINDOW_WORDS) push_packet($urandom(), $urandom(), 1'b0, '0);

        // Wait for the last results, then give the block time to show any stray word.
        drain_results();
        repeat (END_SETTLE) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/pwmam_pkg.sv
rtl/pwmam_if.sv
rtl/pwmam_front.sv
rtl/pwmam_queue.sv
rtl/pwmam_back.sv
rtl/packet_weighted_mean_anomaly_marker_unit.sv
tb/packet_weighted_mean_anomaly_marker_unit_tb.sv
